[rtl/core/cidr_pkg.sv]
package cidr_pkg;

   localparam int CIDR_TABLE_DEPTH = 16;
   localparam int ADDR_BITS = 32;
   localparam int PLEN_BITS = 6;

   localparam logic [2:0] OP_LOOKUP    = 3'd0;
   localparam logic [2:0] OP_ADD_ALLOW = 3'd1;
   localparam logic [2:0] OP_ADD_BLOCK = 3'd2;
   localparam logic [2:0] OP_REM_ALLOW = 3'd3;
   localparam logic [2:0] OP_REM_BLOCK = 3'd4;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NOMATCH = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_WAIT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic vld;
      logic [ADDR_BITS-1:0] mask;
      logic [ADDR_BITS-1:0] net;
   } entry_type;

   typedef struct packed {
      logic clr;
      logic load;
      logic scan;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic idx_last;
      logic out_full;
   } sts_type;

   function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic [PLEN_BITS-1:0] plen);
      logic [PLEN_BITS-1:0] n;
      logic [ADDR_BITS-1:0] m;
      n = (plen > PLEN_BITS'(ADDR_BITS)) ? PLEN_BITS'(ADDR_BITS) : plen;
      if (n == '0) begin
         m = '0;
      end else begin
         m = {ADDR_BITS{1'b1}} << (PLEN_BITS'(ADDR_BITS) - n);
      end
      return m;
   endfunction

endpackage

[rtl/core/cidr_ctrl.sv]
module cidr_ctrl
   import cidr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.idx_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (sts.idx_last) state_in = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!sts.out_full || rsp_tready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load = req_tvalid;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
         end
         S_WAIT: begin
         end
         S_FINISH: begin
            cmd.fin = !sts.out_full || rsp_tready;
         end
         default: begin
         end
      endcase
   end

`ifndef SYNTH
   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_tvalid) |=> (state_ff == S_SCAN))
      else $error("accepted request did not start a scan");
   a_finish_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && rsp_tready) |=> (state_ff == S_IDLE))
      else $error("finished request did not return to idle");
   a_clear_blocks_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!cmd.fin && !cmd.scan))
      else $error("work issued during clear pass");
`endif

endmodule

[rtl/core/cidr_dp.sv]
module cidr_dp
   import cidr_pkg::*;
#(
   parameter int TABLE_DEPTH = CIDR_TABLE_DEPTH
)(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [2:0]  req_tuser,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [7:0]  rsp_tdata
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   entry_type allow_mem [TABLE_DEPTH];
   entry_type block_mem [TABLE_DEPTH];

   entry_type allow_q_ff;
   entry_type block_q_ff;

   logic [2:0]           op_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [ADDR_BITS-1:0] mask_ff;

   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] rd_idx_ff;
   logic          rd_vld_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          blk_hit_ff, blk_hit_in;
   logic          alw_hit_ff, alw_hit_in;
   logic          found_ff, found_in;
   logic          out_vld_ff, out_vld_in;
   logic          out_allowed_ff;
   logic [1:0]    out_status_ff;

   logic                 allow_we, block_we;
   entry_type            allow_wd, block_wd;
   logic [IW-1:0]        wr_idx;
   logic [ADDR_BITS-1:0] key;
   logic                 a_match, b_match, a_rem, b_rem;
   logic                 res_allowed;
   logic [1:0]           res_status;

   assign sts.idx_last = (idx_ff == IW'(TABLE_DEPTH - 1));
   assign sts.out_full = out_vld_ff;

   // table memories
   always_ff @(posedge clock) begin
      if (allow_we) allow_mem[wr_idx] <= allow_wd;
      if (block_we) block_mem[wr_idx] <= block_wd;
      if (cmd.scan) begin
         allow_q_ff <= allow_mem[idx_ff];
         block_q_ff <= block_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_tuser;
         addr_ff <= req_tdata[31:0];
         mask_ff <= prefix_mask(req_tdata[37:32]);
      end
      rd_idx_ff <= idx_ff;
      if (cmd.fin) begin
         out_allowed_ff <= res_allowed;
         out_status_ff  <= res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         cnt_ff     <= '0;
         blk_hit_ff <= 1'b0;
         alw_hit_ff <= 1'b0;
         found_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         rd_vld_ff  <= cmd.scan;
         cnt_ff     <= cnt_in;
         blk_hit_ff <= blk_hit_in;
         alw_hit_ff <= alw_hit_in;
         found_ff   <= found_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.clr || cmd.scan) begin
         idx_in = sts.idx_last ? '0 : idx_ff + IW'(1);
      end
   end

   assign key     = addr_ff & mask_ff;
   assign a_match = allow_q_ff.vld && ((addr_ff & allow_q_ff.mask) == allow_q_ff.net);
   assign b_match = block_q_ff.vld && ((addr_ff & block_q_ff.mask) == block_q_ff.net);
   assign a_rem   = allow_q_ff.vld && (allow_q_ff.net == key) && (allow_q_ff.mask == mask_ff);
   assign b_rem   = block_q_ff.vld && (block_q_ff.net == key) && (block_q_ff.mask == mask_ff);

   // entry evaluation and write back
   always_comb begin
      allow_we   = cmd.clr;
      block_we   = cmd.clr;
      allow_wd   = '0;
      block_wd   = '0;
      wr_idx     = cmd.clr ? idx_ff : rd_idx_ff;
      cnt_in     = cnt_ff;
      blk_hit_in = blk_hit_ff;
      alw_hit_in = alw_hit_ff;
      found_in   = found_ff;
      if (cmd.load) begin
         blk_hit_in = 1'b0;
         alw_hit_in = 1'b0;
         found_in   = 1'b0;
      end else if (rd_vld_ff) begin
         unique case (op_ff)
            OP_LOOKUP: begin
               blk_hit_in = blk_hit_ff | b_match;
               alw_hit_in = alw_hit_ff | a_match;
            end
            OP_ADD_ALLOW: begin
               if (!found_ff && !allow_q_ff.vld) begin
                  allow_we      = 1'b1;
                  allow_wd.vld  = 1'b1;
                  allow_wd.mask = mask_ff;
                  allow_wd.net  = key;
                  found_in      = 1'b1;
                  cnt_in        = cnt_ff + CW'(1);
               end
            end
            OP_ADD_BLOCK: begin
               if (!found_ff && !block_q_ff.vld) begin
                  block_we      = 1'b1;
                  block_wd.vld  = 1'b1;
                  block_wd.mask = mask_ff;
                  block_wd.net  = key;
                  found_in      = 1'b1;
               end
            end
            OP_REM_ALLOW: begin
               if (a_rem) begin
                  allow_we     = 1'b1;
                  allow_wd     = allow_q_ff;
                  allow_wd.vld = 1'b0;
                  found_in     = 1'b1;
                  cnt_in       = cnt_ff - CW'(1);
               end
            end
            OP_REM_BLOCK: begin
               if (b_rem) begin
                  block_we     = 1'b1;
                  block_wd     = block_q_ff;
                  block_wd.vld = 1'b0;
                  found_in     = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      res_allowed = 1'b0;
      res_status  = ST_DONE;
      unique case (op_ff)
         OP_LOOKUP: begin
            res_allowed = !blk_hit_ff && ((cnt_ff == '0) || alw_hit_ff);
         end
         OP_ADD_ALLOW, OP_ADD_BLOCK: begin
            res_status = found_ff ? ST_DONE : ST_FULL;
         end
         OP_REM_ALLOW, OP_REM_BLOCK: begin
            res_status = found_ff ? ST_DONE : ST_NOMATCH;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (cmd.fin) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'd0, out_status_ff, out_allowed_ff};

`ifndef SYNTH
   a_fin_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> (!out_vld_ff || rsp_tready))
      else $error("result overwritten before it was taken");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(TABLE_DEPTH))
      else $error("allow entry count beyond table depth");
   a_single_write: assert property (@(posedge clock) disable iff (reset)
      (rd_vld_ff && allow_we) |-> !block_we)
      else $error("both tables written by one request");
`endif

endmodule

[rtl/core/cidr_allow_block_filter.sv]
// cidr allow/block filter: two tables of ipv4 cidr rules, allow and block
// req channel: req_tuser carries the opcode (lookup, add allow, add block,
// remove allow, remove block), req_tdata the address and prefix length
// rsp channel: one response per request, rsp_tdata holds the lookup verdict
// and the status (done, table full on add, no match on remove)
// each request walks both tables one entry per cycle through the single read
// port of each table memory; one request is in flight at a time, so the next
// request is accepted only after the previous one has reached the response
// register
// after reset a clearing pass over every entry zeroes both tables, with
// req_tready held low
// the response sits in an output register: the next request is accepted
// while it waits, and a stalled receiver holds the following response back
// until the register has been emptied
module cidr_allow_block_filter
   import cidr_pkg::*;
#(
   parameter int TABLE_DEPTH = CIDR_TABLE_DEPTH
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   input  logic [39:0] req_tdata,   // [31:0] address, [37:32] prefix_len, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] allowed, [2:1] status, rest zero
);

   cmd_type cmd;
   sts_type sts;

   cidr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cidr_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
